/* src/segment_polygon_intersect_top_assert.svh */
// Assertion macros used by the top-level RTL file.
`ifndef SEGMENT_POLYGON_INTERSECT_TOP_ASSERT_SVH
`define SEGMENT_POLYGON_INTERSECT_TOP_ASSERT_SVH

// Checks that cons holds in the same cycle as ante.
`define SPI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that cons holds in the cycle after ante.
`define SPI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/spi_pkg.sv */
package spi_pkg;

    localparam int unsigned NUM_DATA_FIELDS = 6;
    localparam int unsigned OUT_DATA_W      = 8;

    typedef struct packed {
        logic start;
        logic last;
    } t_item_ctl;

endpackage

/* src/spi_setup.sv */
module spi_setup
    import spi_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic signed [COORD_WIDTH-1:0] i_item_sx,
    input  logic signed [COORD_WIDTH-1:0] i_item_sy,
    input  logic signed [COORD_WIDTH-1:0] i_item_ex,
    input  logic signed [COORD_WIDTH-1:0] i_item_ey,
    input  logic signed [COORD_WIDTH-1:0] i_vx,
    input  logic signed [COORD_WIDTH-1:0] i_vy,
    input  logic                          i_last,
    input  logic signed [COORD_WIDTH-1:0] i_held_sx,
    input  logic signed [COORD_WIDTH-1:0] i_held_sy,
    input  logic signed [COORD_WIDTH-1:0] i_held_ex,
    input  logic signed [COORD_WIDTH-1:0] i_held_ey,
    input  logic signed [COORD_WIDTH-1:0] i_prev_x,
    input  logic signed [COORD_WIDTH-1:0] i_prev_y,
    input  logic signed [COORD_WIDTH-1:0] i_first_x,
    input  logic signed [COORD_WIDTH-1:0] i_first_y,
    input  logic                          i_inside,
    output logic signed [COORD_WIDTH:0]   o_ax,
    output logic signed [COORD_WIDTH:0]   o_ay,
    output logic signed [COORD_WIDTH:0]   o_bx_a,
    output logic signed [COORD_WIDTH:0]   o_by_a,
    output logic signed [COORD_WIDTH:0]   o_cx_a,
    output logic signed [COORD_WIDTH:0]   o_cy_a,
    output logic signed [COORD_WIDTH:0]   o_bx_b,
    output logic signed [COORD_WIDTH:0]   o_by_b,
    output logic signed [COORD_WIDTH:0]   o_cx_b,
    output logic signed [COORD_WIDTH:0]   o_cy_b,
    output t_item_ctl                     o_ctl
);

    localparam int DW = COORD_WIDTH + 1;

    logic signed [COORD_WIDTH-1:0] p0x, p0y, p1x, p1y;
    logic signed [COORD_WIDTH-1:0] fx, fy;

    // The first vertex of a polygon supplies the segment and is its own first vertex.
    assign p0x = i_inside ? i_held_sx : i_item_sx;
    assign p0y = i_inside ? i_held_sy : i_item_sy;
    assign p1x = i_inside ? i_held_ex : i_item_ex;
    assign p1y = i_inside ? i_held_ey : i_item_ey;
    assign fx  = i_inside ? i_first_x : i_vx;
    assign fy  = i_inside ? i_first_y : i_vy;

    assign o_ax   = DW'(p1x) - DW'(p0x);
    assign o_ay   = DW'(p1y) - DW'(p0y);

    // Edge from the previous vertex to the current one.
    assign o_bx_a = DW'(i_prev_x) - DW'(i_vx);
    assign o_by_a = DW'(i_prev_y) - DW'(i_vy);
    assign o_cx_a = DW'(p0x) - DW'(i_prev_x);
    assign o_cy_a = DW'(p0y) - DW'(i_prev_y);

    // Closing edge from the current vertex back to the first one.
    assign o_bx_b = DW'(i_vx) - DW'(fx);
    assign o_by_b = DW'(i_vy) - DW'(fy);
    assign o_cx_b = DW'(p0x) - DW'(i_vx);
    assign o_cy_b = DW'(p0y) - DW'(i_vy);

    assign o_ctl.start = ~i_inside;
    assign o_ctl.last  = i_last;

endmodule

/* src/spi_edge_prod.sv */
module spi_edge_prod #(
    parameter int COORD_WIDTH = 16
) (
    input  logic signed [COORD_WIDTH:0]         i_ax,
    input  logic signed [COORD_WIDTH:0]         i_ay,
    input  logic signed [COORD_WIDTH:0]         i_bx,
    input  logic signed [COORD_WIDTH:0]         i_by,
    input  logic signed [COORD_WIDTH:0]         i_cx,
    input  logic signed [COORD_WIDTH:0]         i_cy,
    output logic signed [2*COORD_WIDTH+1:0]     o_den_p,
    output logic signed [2*COORD_WIDTH+1:0]     o_den_n,
    output logic signed [2*COORD_WIDTH+1:0]     o_alpha_p,
    output logic signed [2*COORD_WIDTH+1:0]     o_alpha_n,
    output logic signed [2*COORD_WIDTH+1:0]     o_beta_p,
    output logic signed [2*COORD_WIDTH+1:0]     o_beta_n
);

    localparam int PW = 2 * COORD_WIDTH + 2;

    assign o_den_p   = PW'(i_ay) * PW'(i_bx);
    assign o_den_n   = PW'(i_ax) * PW'(i_by);
    assign o_alpha_p = PW'(i_by) * PW'(i_cx);
    assign o_alpha_n = PW'(i_bx) * PW'(i_cy);
    assign o_beta_p  = PW'(i_ax) * PW'(i_cy);
    assign o_beta_n  = PW'(i_ay) * PW'(i_cx);

endmodule

/* src/spi_edge_test.sv */
module spi_edge_test #(
    parameter int COORD_WIDTH = 16
) (
    input  logic signed [2*COORD_WIDTH+1:0] i_den_p,
    input  logic signed [2*COORD_WIDTH+1:0] i_den_n,
    input  logic signed [2*COORD_WIDTH+1:0] i_alpha_p,
    input  logic signed [2*COORD_WIDTH+1:0] i_alpha_n,
    input  logic signed [2*COORD_WIDTH+1:0] i_beta_p,
    input  logic signed [2*COORD_WIDTH+1:0] i_beta_n,
    output logic                            o_hit
);

    localparam int SW = 2 * COORD_WIDTH + 3;

    logic signed [SW-1:0] den, alpha, beta;
    logic                 alpha_ok, beta_ok;

    assign den   = SW'(i_den_p) - SW'(i_den_n);
    assign alpha = SW'(i_alpha_p) - SW'(i_alpha_n);
    assign beta  = SW'(i_beta_p) - SW'(i_beta_n);

    // Both bounds are inclusive; the interval runs toward the sign of the denominator.
    always_comb begin
        if (den > 0) begin
            alpha_ok = (alpha >= 0) && (alpha <= den);
            beta_ok  = (beta >= 0) && (beta <= den);
        end else begin
            alpha_ok = (alpha <= 0) && (alpha >= den);
            beta_ok  = (beta <= 0) && (beta >= den);
        end
    end

    assign o_hit = (den != 0) && alpha_ok && beta_ok;

endmodule

/* src/segment_polygon_intersect_top.sv */
// Segment versus polygon crossing test.
// The slave channel takes one polygon vertex per transfer. i_s_tdata carries the
// query segment and the vertex, and i_s_tlast marks the last vertex of a polygon.
// The segment fields are used only from the first vertex of each polygon.
// Each vertex tests the edge from the previous vertex, and the last vertex also
// tests the closing edge back to the first vertex.
// The master channel gives one transfer per polygon, with the crossing flag in
// bit 0 of o_m_tdata, once the last vertex has passed through the pipeline.
// A new vertex can be taken in every cycle while the output is not stalled; it
// passes an input register, a setup, a multiply and a compare stage.
// When the receiver stalls, the result waits in the output register, and
// vertices keep flowing until a later last vertex reaches the compare stage.
// A synchronous reset empties the pipeline, drops any pending result and makes
// the next vertex the start of a new polygon.
module segment_polygon_intersect_top
    import spi_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // From bit 0: seg_start_x, seg_start_y, seg_end_x, seg_end_y, vertex_x,
    // vertex_y, zero fill.
    input  logic [((NUM_DATA_FIELDS*COORD_WIDTH+7)/8)*8-1:0] i_s_tdata,
    input  logic                                  i_s_tlast,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // From bit 0: crosses, zero fill.
    output logic [OUT_DATA_W-1:0]                 o_m_tdata
);

    `include "segment_polygon_intersect_top_assert.svh"

    localparam int W  = COORD_WIDTH;
    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * COORD_WIDTH + 2;

    // Stage 1: input register.
    logic                r_v1;
    logic signed [W-1:0] r_sx, r_sy, r_ex, r_ey, r_vx, r_vy;
    logic                r_last1;

    // Polygon state.
    logic                r_inside;
    logic signed [W-1:0] r_held_sx, r_held_sy, r_held_ex, r_held_ey;
    logic signed [W-1:0] r_prev_x, r_prev_y, r_first_x, r_first_y;

    // Stage 2: differences.
    logic                 r_v2;
    t_item_ctl            r_ctl2;
    logic signed [DW-1:0] r_ax, r_ay;
    logic signed [DW-1:0] r_bx_a, r_by_a, r_cx_a, r_cy_a;
    logic signed [DW-1:0] r_bx_b, r_by_b, r_cx_b, r_cy_b;

    // Stage 3: products.
    logic                 r_v3;
    t_item_ctl            r_ctl3;
    logic signed [PW-1:0] r_pa [6];
    logic signed [PW-1:0] r_pb [6];

    // Accumulator and output register.
    logic r_hit;
    logic r_out_valid;
    logic r_out_crosses;

    t_item_ctl            ctl1;
    logic signed [DW-1:0] ax, ay, bx_a, by_a, cx_a, cy_a, bx_b, by_b, cx_b, cy_b;
    logic signed [PW-1:0] pa [6];
    logic signed [PW-1:0] pb [6];
    logic                 hit_a, hit_b;
    logic                 n_hit;
    logic                 leave3, load3, load2, load1;

    assign leave3 = ~r_ctl3.last | ~r_out_valid | i_m_tready;
    assign load3  = ~r_v3 | leave3;
    assign load2  = ~r_v2 | load3;
    assign load1  = ~r_v1 | load2;

    assign o_s_tready = load1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (load1) begin
            r_v1 <= i_s_tvalid;
        end
        if (load1) begin
            r_sx    <= i_s_tdata[0*W +: W];
            r_sy    <= i_s_tdata[1*W +: W];
            r_ex    <= i_s_tdata[2*W +: W];
            r_ey    <= i_s_tdata[3*W +: W];
            r_vx    <= i_s_tdata[4*W +: W];
            r_vy    <= i_s_tdata[5*W +: W];
            r_last1 <= i_s_tlast;
        end
    end

    spi_setup #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_setup (
        .i_item_sx (r_sx),
        .i_item_sy (r_sy),
        .i_item_ex (r_ex),
        .i_item_ey (r_ey),
        .i_vx      (r_vx),
        .i_vy      (r_vy),
        .i_last    (r_last1),
        .i_held_sx (r_held_sx),
        .i_held_sy (r_held_sy),
        .i_held_ex (r_held_ex),
        .i_held_ey (r_held_ey),
        .i_prev_x  (r_prev_x),
        .i_prev_y  (r_prev_y),
        .i_first_x (r_first_x),
        .i_first_y (r_first_y),
        .i_inside  (r_inside),
        .o_ax      (ax),
        .o_ay      (ay),
        .o_bx_a    (bx_a),
        .o_by_a    (by_a),
        .o_cx_a    (cx_a),
        .o_cy_a    (cy_a),
        .o_bx_b    (bx_b),
        .o_by_b    (by_b),
        .o_cx_b    (cx_b),
        .o_cy_b    (cy_b),
        .o_ctl     (ctl1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_v2     <= 1'b0;
        end else begin
            if (load2) begin
                r_v2 <= r_v1;
            end
            if (r_v1 && load2) begin
                r_inside <= ~r_last1;
            end
        end
        if (r_v1 && load2) begin
            if (!r_inside) begin
                r_held_sx <= r_sx;
                r_held_sy <= r_sy;
                r_held_ex <= r_ex;
                r_held_ey <= r_ey;
                r_first_x <= r_vx;
                r_first_y <= r_vy;
            end
            r_prev_x <= r_vx;
            r_prev_y <= r_vy;
        end
        if (load2) begin
            r_ctl2 <= ctl1;
            r_ax   <= ax;
            r_ay   <= ay;
            r_bx_a <= bx_a;
            r_by_a <= by_a;
            r_cx_a <= cx_a;
            r_cy_a <= cy_a;
            r_bx_b <= bx_b;
            r_by_b <= by_b;
            r_cx_b <= cx_b;
            r_cy_b <= cy_b;
        end
    end

    spi_edge_prod #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_prod_prev (
        .i_ax      (r_ax),
        .i_ay      (r_ay),
        .i_bx      (r_bx_a),
        .i_by      (r_by_a),
        .i_cx      (r_cx_a),
        .i_cy      (r_cy_a),
        .o_den_p   (pa[0]),
        .o_den_n   (pa[1]),
        .o_alpha_p (pa[2]),
        .o_alpha_n (pa[3]),
        .o_beta_p  (pa[4]),
        .o_beta_n  (pa[5])
    );

    spi_edge_prod #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_prod_close (
        .i_ax      (r_ax),
        .i_ay      (r_ay),
        .i_bx      (r_bx_b),
        .i_by      (r_by_b),
        .i_cx      (r_cx_b),
        .i_cy      (r_cy_b),
        .o_den_p   (pb[0]),
        .o_den_n   (pb[1]),
        .o_alpha_p (pb[2]),
        .o_alpha_n (pb[3]),
        .o_beta_p  (pb[4]),
        .o_beta_n  (pb[5])
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (load3) begin
            r_v3 <= r_v2;
        end
        if (load3) begin
            r_ctl3 <= r_ctl2;
            r_pa   <= pa;
            r_pb   <= pb;
        end
    end

    spi_edge_test #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_test_prev (
        .i_den_p   (r_pa[0]),
        .i_den_n   (r_pa[1]),
        .i_alpha_p (r_pa[2]),
        .i_alpha_n (r_pa[3]),
        .i_beta_p  (r_pa[4]),
        .i_beta_n  (r_pa[5]),
        .o_hit     (hit_a)
    );

    spi_edge_test #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_test_close (
        .i_den_p   (r_pb[0]),
        .i_den_n   (r_pb[1]),
        .i_alpha_p (r_pb[2]),
        .i_alpha_n (r_pb[3]),
        .i_beta_p  (r_pb[4]),
        .i_beta_n  (r_pb[5]),
        .o_hit     (hit_b)
    );

    // The first vertex of a polygon has no edge to a previous vertex.
    assign n_hit = (~r_ctl3.start & r_hit) | (~r_ctl3.start & hit_a) | (r_ctl3.last & hit_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_v3 && leave3) begin
                r_hit <= n_hit;
            end
            if (r_v3 && r_ctl3.last && leave3) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (r_v3 && r_ctl3.last && leave3) begin
            r_out_crosses <= n_hit;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W-1){1'b0}}, r_out_crosses};

    `SPI_ASSERT_IMP(a_result_from_last, i_clk, i_rst_n, $rose(o_m_tvalid), $past(r_v3 && r_ctl3.last), "result without a last vertex")
    `SPI_ASSERT_IMP(a_single_vertex_no_hit, i_clk, i_rst_n, r_v3 && r_ctl3.start && r_ctl3.last, !hit_b, "single-vertex polygon reported a crossing")
    `SPI_ASSERT_NXT(a_inside_after_vertex, i_clk, i_rst_n, r_v1 && load2 && !r_last1, r_inside, "polygon state lost after a middle vertex")
    `SPI_ASSERT_NXT(a_outside_after_last, i_clk, i_rst_n, r_v1 && load2 && r_last1, !r_inside, "polygon not closed after its last vertex")

endmodule

/* tb/sv/segment_polygon_intersect_top_tb.sv */
module segment_polygon_intersect_top_tb;
    import spi_pkg::*;

    localparam int COORD_W     = 16;
    localparam int S_DATA_W    = ((NUM_DATA_FIELDS * COORD_W + 7) / 8) * 8;
    localparam int TARGET_ITEMS = 1250;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct {
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        coord_t vx;
        coord_t vy;
        bit     is_last;
    } vertex_item_t;

    typedef enum int {
        SPAN_TINY,
        SPAN_MID,
        SPAN_FULL
    } coord_span_e;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                drv_tvalid = 1'b0;
    logic [S_DATA_W-1:0] drv_tdata = '0;
    logic                drv_tlast = 1'b0;
    logic                rx_tready = 1'b0;
    logic                o_s_tready;
    logic                o_m_tvalid;
    logic [OUT_DATA_W-1:0] o_m_tdata;

    vertex_item_t vertex_queue[$];
    bit           crossing_flags[$];

    coord_t poly_first_x, poly_first_y, poly_prev_x, poly_prev_y;
    coord_t seg_sx, seg_sy, seg_ex, seg_ey;
    bit     hit_so_far = 1'b0;
    bit     in_polygon = 1'b0;

    vertex_item_t drv_item;
    int           drv_gap = 0;
    int           vertices_sent = 0;
    int           rx_stall = 0;
    int           results_seen = 0;
    int           crossings_seen = 0;
    int           error_count = 0;
    int           cycle_count = 0;

    segment_polygon_intersect_top #(
        .COORD_WIDTH(COORD_W)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (drv_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (drv_tdata),
        .i_s_tlast  (drv_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (rx_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    function automatic bit within_bounds(input longint num, input longint den);
        if (den > 0) begin
            return (num >= 0) && (num <= den);
        end
        return (num <= 0) && (num >= den);
    endfunction

    function automatic bit segment_meets_edge(input coord_t e0x, input coord_t e0y,
                                              input coord_t e1x, input coord_t e1y);
        longint ax, ay, bx, by, cx, cy, den, alpha, beta;
        ax = longint'(seg_ex) - longint'(seg_sx);
        ay = longint'(seg_ey) - longint'(seg_sy);
        bx = longint'(e0x) - longint'(e1x);
        by = longint'(e0y) - longint'(e1y);
        cx = longint'(seg_sx) - longint'(e0x);
        cy = longint'(seg_sy) - longint'(e0y);
        den = ay * bx - ax * by;
        if (den == 0) begin
            return 1'b0;
        end
        alpha = by * cx - bx * cy;
        if (!within_bounds(alpha, den)) begin
            return 1'b0;
        end
        beta = ax * cy - ay * cx;
        return within_bounds(beta, den);
    endfunction

    // Updates the polygon state for one accepted vertex and queues the flag
    // that the polygon's last vertex produces.
    task automatic track_vertex(input vertex_item_t it);
        if (!in_polygon) begin
            seg_sx = it.sx;
            seg_sy = it.sy;
            seg_ex = it.ex;
            seg_ey = it.ey;
            poly_first_x = it.vx;
            poly_first_y = it.vy;
            hit_so_far = 1'b0;
            in_polygon = 1'b1;
        end else if (segment_meets_edge(poly_prev_x, poly_prev_y, it.vx, it.vy)) begin
            hit_so_far = 1'b1;
        end
        poly_prev_x = it.vx;
        poly_prev_y = it.vy;
        if (it.is_last) begin
            if (segment_meets_edge(it.vx, it.vy, poly_first_x, poly_first_y)) begin
                hit_so_far = 1'b1;
            end
            crossing_flags.push_back(hit_so_far);
            in_polygon = 1'b0;
        end
    endtask

    task automatic push_vertex(input int sx, input int sy, input int ex, input int ey,
                               input int vx, input int vy, input bit is_last);
        vertex_item_t it;
        it.sx = coord_t'(sx);
        it.sy = coord_t'(sy);
        it.ex = coord_t'(ex);
        it.ey = coord_t'(ey);
        it.vx = coord_t'(vx);
        it.vy = coord_t'(vy);
        it.is_last = is_last;
        vertex_queue.push_back(it);
    endtask

    function automatic int rand_coord(input coord_span_e span);
        case (span)
            SPAN_TINY: begin
                return $urandom_range(0, 32) - 16;
            end
            SPAN_MID: begin
                return $urandom_range(0, 2000) - 1000;
            end
            default: begin
                return int'(coord_t'($urandom));
            end
        endcase
    endfunction

    // Driver: a vertex stays presented until its transfer, then the next one
    // follows after a random gap.
    always @(posedge i_clk) begin : driver
        bit quiet;
        if (!i_rst_n) begin
            drv_tvalid <= 1'b0;
            drv_gap <= 0;
        end else begin
            if (drv_tvalid && o_s_tready) begin
                track_vertex(drv_item);
                vertices_sent++;
            end
            if (!drv_tvalid || o_s_tready) begin
                if (drv_gap > 0) begin
                    drv_gap <= drv_gap - 1;
                    drv_tvalid <= 1'b0;
                end else if (vertex_queue.size() > 0) begin
                    quiet = (vertices_sent % 300) < 80;
                    drv_item = vertex_queue.pop_front();
                    drv_tvalid <= 1'b1;
                    drv_tdata <= {drv_item.vy, drv_item.vx, drv_item.ey, drv_item.ex,
                                  drv_item.sy, drv_item.sx};
                    drv_tlast <= drv_item.is_last;
                    drv_gap <= quiet ? 0 : $urandom_range(0, 7);
                end else begin
                    drv_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transfer and stalls the receiver at random.
    always @(posedge i_clk) begin : monitor
        bit exp_flag;
        int stall;
        if (!i_rst_n) begin
            rx_tready <= 1'b0;
            rx_stall <= 0;
        end else begin
            stall = rx_stall;
            if (o_m_tvalid && rx_tready) begin
                results_seen++;
                if (o_m_tdata[0]) begin
                    crossings_seen++;
                end
                if (crossing_flags.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, crosses=%0b", o_m_tdata[0]));
                end else begin
                    exp_flag = crossing_flags.pop_front();
                    if (o_m_tdata[0] !== exp_flag) begin
                        report_mismatch($sformatf("result %0d: crosses=%0b, expected %0b",
                                                  results_seen, o_m_tdata[0], exp_flag));
                    end
                end
                stall = ((results_seen % 40) < 10) ? 0 : $urandom_range(0, 7);
            end
            if (stall > 0) begin
                rx_tready <= 1'b0;
                rx_stall <= stall - 1;
            end else begin
                rx_tready <= 1'b1;
                rx_stall <= 0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stimulus
        int nverts, total, sx, sy, ex, ey;
        coord_span_e span;
        int pick;

        // Polygon of one vertex: the closing edge is a point.
        push_vertex(0, 0, 10, 10, 5, 5, 1'b1);
        // Triangle crossed by a horizontal segment.
        push_vertex(-100, 0, 100, 0, 0, -50, 1'b0);
        push_vertex(-7, 9, 3, -2, 50, 50, 1'b0);
        push_vertex(11, 12, 13, 14, -50, 50, 1'b1);
        // Same triangle, segment passes above it.
        push_vertex(-100, 200, 100, 200, 0, -50, 1'b0);
        push_vertex(0, 0, 0, 0, 50, 50, 1'b0);
        push_vertex(0, 0, 0, 0, -50, 50, 1'b1);
        // Segment of zero length inside a triangle.
        push_vertex(7, 7, 7, 7, 0, 0, 1'b0);
        push_vertex(-100, 0, 100, 0, 20, 0, 1'b0);
        push_vertex(0, 0, 0, 0, 10, 20, 1'b1);
        // Segment end touches the closing edge only.
        push_vertex(0, 0, 10, 0, 10, -5, 1'b0);
        push_vertex(0, 0, 0, 0, 20, -5, 1'b0);
        push_vertex(0, 0, 0, 0, 20, 5, 1'b0);
        push_vertex(0, 0, 0, 0, 10, 5, 1'b1);
        // Edge collinear with the segment: parallel, so no crossing.
        push_vertex(0, 0, 10, 0, 2, 0, 1'b0);
        push_vertex(0, 0, 0, 0, 8, 0, 1'b1);
        // Full-scale diagonals; later segment fields are ignored.
        push_vertex(-32768, -32768, 32767, 32767, -32768, 32767, 1'b0);
        push_vertex(32767, 32767, -32768, -32768, 32767, -32768, 1'b1);
        push_vertex(32767, -32768, -32768, 32767, -32768, -32768, 1'b0);
        push_vertex(-1, -1, -1, -1, 32767, 32767, 1'b0);
        push_vertex(-32768, 32767, 0, -1, 32767, -32768, 1'b1);

        total = vertex_queue.size();
        while (total < TARGET_ITEMS) begin
            pick = $urandom_range(0, 99);
            span = (pick < 60) ? SPAN_TINY : (pick < 85) ? SPAN_MID : SPAN_FULL;
            nverts = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20)
                                                 : $urandom_range(1, 8);
            sx = rand_coord(span);
            sy = rand_coord(span);
            if ($urandom_range(0, 19) == 0) begin
                ex = sx;
                ey = sy;
            end else begin
                ex = rand_coord(span);
                ey = rand_coord(span);
            end
            for (int i = 0; i < nverts; i++) begin
                if (i == 0) begin
                    push_vertex(sx, sy, ex, ey, rand_coord(span), rand_coord(span),
                                nverts == 1);
                end else begin
                    push_vertex(rand_coord(SPAN_FULL), rand_coord(SPAN_FULL),
                                rand_coord(SPAN_FULL), rand_coord(SPAN_FULL),
                                rand_coord(span), rand_coord(span), i == nverts - 1);
                end
            end
            total += nverts;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (vertex_queue.size() > 0 || drv_tvalid || crossing_flags.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d vertices; checked %0d polygon results, %0d of them crossings.",
                 vertices_sent, results_seen, crossings_seen);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Mismatches: %0d", error_count);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
